FILE: rtl/pfe_pkg.sv
// shared constants and cell arithmetic for the playfair encryptor
package pfe_pkg;

   localparam int LW = 5;

   localparam logic [LW-1:0] LETTER_I    = 5'd8;
   localparam logic [LW-1:0] LETTER_J    = 5'd9;
   localparam logic [LW-1:0] LETTER_Q    = 5'd16;
   localparam logic [LW-1:0] LETTER_X    = 5'd23;
   localparam logic [LW-1:0] LAST_LETTER = 5'd25;
   localparam logic [LW-1:0] CELLS       = 5'd25;
   localparam logic [LW-1:0] SIDE        = 5'd5;
   localparam logic [2:0]    LAST_COL    = 3'd4;
   localparam int            LETTERS     = 26;

   localparam logic REQ_KEY = 1'b0;
   localparam logic REQ_MSG = 1'b1;

   // j shares the cell of i
   function automatic logic [LW-1:0] lookup_letter(input logic [LW-1:0] l);
      logic [LW-1:0] r;
      r = (l == LETTER_J) ? LETTER_I : l;
      return r;
   endfunction

   function automatic logic [2:0] cell_row(input logic [LW-1:0] c);
      logic [2:0] r;
      r = 3'd0;
      if (c >= 5'd20) begin
         r = 3'd4;
      end else if (c >= 5'd15) begin
         r = 3'd3;
      end else if (c >= 5'd10) begin
         r = 3'd2;
      end else if (c >= 5'd5) begin
         r = 3'd1;
      end
      return r;
   endfunction

   function automatic logic [2:0] cell_col(input logic [LW-1:0] c);
      logic [LW-1:0] base;
      base = 5'(5'(cell_row(c)) * SIDE);
      return 3'(c - base);
   endfunction

   function automatic logic [LW-1:0] cell_at(input logic [2:0] r, input logic [2:0] k);
      logic [LW-1:0] c;
      c = 5'(5'(r) * SIDE + 5'(k));
      return c;
   endfunction

   function automatic logic [2:0] wrap_inc(input logic [2:0] k);
      logic [2:0] r;
      r = (k == LAST_COL) ? 3'd0 : 3'(k + 3'd1);
      return r;
   endfunction

endpackage

FILE: rtl/playfair_encryptor_top.sv
// playfair encryptor: square build, letter pairing and pair encryption
//
// The key letter marked last adds a walk over the alphabet that completes the
// square, one letter per cycle. A message letter that only waits for its partner
// is held; one that completes a pair, and a second pair after a final doubled
// letter, is encrypted by four one-port reads in turn (two cell lookups in the
// position memory, two letter reads in the square memory). A message letter
// arriving while the square is incomplete first runs the walk. Results wait in an
// output register, so the next letter is taken while a result is stalled.
module playfair_encryptor_top
   import pfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_type,
   input  logic [LW-1:0] req_letter,
   input  logic          req_last,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [LW-1:0] rsp_first_cipher,
   output logic [LW-1:0] rsp_second_cipher,
   output logic          rsp_last_pair
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_KEY,
      S_FILL,
      S_PAIR,
      S_POS_A,
      S_POS_B,
      S_CELL,
      S_SQ_A,
      S_SQ_B,
      S_OUT
   } state_type;

   state_type state_ff;

   logic                key_open_ff;
   logic [LETTERS-1:0]  used_ff;
   logic [LW-1:0]       fill_ff;
   logic [LW-1:0]       walk_ff;
   logic                pend_valid_ff;
   logic [LW-1:0]       pend_letter_ff;

   logic                item_type_ff;
   logic [LW-1:0]       item_letter_ff;
   logic                item_last_ff;

   logic [LW-1:0]       pa_ff;
   logic [LW-1:0]       pb_ff;
   logic                plast_ff;
   logic                two_ff;
   logic [LW-1:0]       ca_ff;
   logic [LW-1:0]       oa_ff;
   logic [LW-1:0]       ob_ff;
   logic [LW-1:0]       first_ff;

   logic                rsp_valid_ff;
   logic [LW-1:0]       rsp_first_ff;
   logic [LW-1:0]       rsp_second_ff;
   logic                rsp_last_ff;

   logic [LW-1:0]       sq_mem [CELLS];
   logic [LW-1:0]       pos_mem [LETTERS];
   logic [LW-1:0]       pos_q_ff;
   logic [LW-1:0]       sq_q_ff;

   logic [LW-1:0]       in_letter;
   logic                req_xfer;
   logic [LW-1:0]       cand;
   logic                place_en;
   logic [LW-1:0]       pos_addr;
   logic [LW-1:0]       sq_addr;
   logic [LW-1:0]       ca;
   logic [LW-1:0]       cb;
   logic [2:0]          ra;
   logic [2:0]          ka;
   logic [2:0]          rb;
   logic [2:0]          kb;
   logic [LW-1:0]       oa_in;
   logic [LW-1:0]       ob_in;

   assign req_stall         = (state_ff != S_IDLE);
   assign req_xfer          = req_valid && !req_stall;
   assign in_letter         = (req_letter > LAST_LETTER) ? LAST_LETTER : req_letter;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_cipher  = rsp_first_ff;
   assign rsp_second_cipher = rsp_second_ff;
   assign rsp_last_pair     = rsp_last_ff;

   always_comb begin
      cand     = (state_ff == S_FILL) ? walk_ff : item_letter_ff;
      place_en = ((state_ff == S_KEY) || (state_ff == S_FILL))
                 && (fill_ff < CELLS) && !used_ff[cand];
      pos_addr = (state_ff == S_POS_A) ? lookup_letter(pa_ff) : lookup_letter(pb_ff);
      sq_addr  = (state_ff == S_SQ_A) ? oa_ff : ob_ff;
   end

   always_comb begin
      ca = (ca_ff < CELLS) ? ca_ff : '0;
      cb = (pos_q_ff < CELLS) ? pos_q_ff : '0;
      ra = cell_row(ca);
      ka = cell_col(ca);
      rb = cell_row(cb);
      kb = cell_col(cb);
      if (ra == rb) begin
         oa_in = cell_at(ra, wrap_inc(ka));
         ob_in = cell_at(rb, wrap_inc(kb));
      end else if (ka == kb) begin
         oa_in = cell_at(wrap_inc(ra), ka);
         ob_in = cell_at(wrap_inc(rb), kb);
      end else begin
         oa_in = cell_at(ra, kb);
         ob_in = cell_at(rb, ka);
      end
   end

   // square and position memories
   always_ff @(posedge clock) begin
      if (place_en) begin
         sq_mem[fill_ff] <= cand;
         pos_mem[cand]   <= fill_ff;
      end
      pos_q_ff <= pos_mem[pos_addr];
      sq_q_ff  <= sq_mem[sq_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         key_open_ff    <= 1'b0;
         used_ff        <= LETTERS'(1) << LETTER_J;
         fill_ff        <= '0;
         walk_ff        <= '0;
         pend_valid_ff  <= 1'b0;
         pend_letter_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (place_en) begin
            used_ff[cand] <= 1'b1;
            fill_ff       <= 5'(fill_ff + 5'd1);
         end
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  item_type_ff   <= req_type;
                  item_letter_ff <= in_letter;
                  item_last_ff   <= req_last;
                  walk_ff        <= '0;
                  if (req_type == REQ_KEY) begin
                     if (!key_open_ff) begin
                        used_ff        <= LETTERS'(1) << LETTER_J;
                        fill_ff        <= '0;
                        pend_valid_ff  <= 1'b0;
                        pend_letter_ff <= '0;
                     end
                     state_ff <= S_KEY;
                  end else if (key_open_ff || (fill_ff < CELLS)) begin
                     state_ff <= S_FILL;
                  end else begin
                     state_ff <= S_PAIR;
                  end
               end
            end
            S_KEY: begin
               if (item_last_ff) begin
                  state_ff <= S_FILL;
               end else begin
                  key_open_ff <= 1'b1;
                  state_ff    <= S_IDLE;
               end
            end
            S_FILL: begin
               walk_ff <= 5'(walk_ff + 5'd1);
               if (walk_ff == LAST_LETTER) begin
                  key_open_ff <= 1'b0;
                  state_ff    <= (item_type_ff == REQ_MSG) ? S_PAIR : S_IDLE;
               end
            end
            S_PAIR: begin
               if (!pend_valid_ff) begin
                  if (item_last_ff) begin
                     pa_ff    <= item_letter_ff;
                     pb_ff    <= LETTER_X;
                     plast_ff <= 1'b1;
                     two_ff   <= 1'b0;
                     state_ff <= S_POS_A;
                  end else begin
                     pend_valid_ff  <= 1'b1;
                     pend_letter_ff <= item_letter_ff;
                     state_ff       <= S_IDLE;
                  end
               end else if (pend_letter_ff == item_letter_ff) begin
                  // doubled letter: the new one stays waiting unless it is final
                  pa_ff    <= item_letter_ff;
                  pb_ff    <= (item_letter_ff == LETTER_X) ? LETTER_Q : LETTER_X;
                  plast_ff <= 1'b0;
                  two_ff   <= item_last_ff;
                  if (item_last_ff) begin
                     pend_valid_ff  <= 1'b0;
                     pend_letter_ff <= '0;
                  end
                  state_ff <= S_POS_A;
               end else begin
                  pa_ff          <= pend_letter_ff;
                  pb_ff          <= item_letter_ff;
                  plast_ff       <= item_last_ff;
                  two_ff         <= 1'b0;
                  pend_valid_ff  <= 1'b0;
                  pend_letter_ff <= '0;
                  state_ff       <= S_POS_A;
               end
            end
            S_POS_A: begin
               state_ff <= S_POS_B;
            end
            S_POS_B: begin
               ca_ff    <= pos_q_ff;
               state_ff <= S_CELL;
            end
            S_CELL: begin
               oa_ff    <= oa_in;
               ob_ff    <= ob_in;
               state_ff <= S_SQ_A;
            end
            S_SQ_A: begin
               state_ff <= S_SQ_B;
            end
            S_SQ_B: begin
               first_ff <= sq_q_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_first_ff  <= first_ff;
                  rsp_second_ff <= sq_q_ff;
                  rsp_last_ff   <= plast_ff;
                  if (two_ff) begin
                     pa_ff    <= item_letter_ff;
                     pb_ff    <= LETTER_X;
                     plast_ff <= 1'b1;
                     two_ff   <= 1'b0;
                     state_ff <= S_POS_A;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: tb/tb_playfair_encryptor_top.sv
// self-checking testbench for the playfair encryptor: square build, pairing and encryption
`timescale 1ns / 1ps

module tb_playfair_encryptor_top
   import pfe_pkg::*;
();

   localparam int ITEMS      = 1650;
   localparam int IDLE_LIMIT = 5000;
   localparam int HOLD_LEN   = 300;

   typedef struct {
      logic [LW-1:0] first;
      logic [LW-1:0] second;
      logic          last_pair;
   } cipher_pair_type;

   class cipher_scoreboard;
      logic [LW-1:0]   grid[25];
      logic [LW-1:0]   where_is[26];
      logic [25:0]     placed;
      int              filled;
      bit              waiting;
      logic [LW-1:0]   held;
      bit              key_active;
      cipher_pair_type due_pairs[$];
      int              errors;

      function new();
         reset_square();
         key_active = 0;
         errors = 0;
      endfunction

      function void reset_square();
         foreach (grid[i]) grid[i] = '0;
         foreach (where_is[i]) where_is[i] = '0;
         placed = 26'b1 << LETTER_J;
         filled = 0;
         waiting = 0;
         held = '0;
      endfunction

      function void put_letter(int l);
         if (filled >= CELLS || placed[l]) return;
         grid[filled] = LW'(l);
         where_is[l] = LW'(filled);
         placed[l] = 1'b1;
         filled++;
      endfunction

      function void fill_rest();
         for (int l = 0; l < LETTERS; l++) put_letter(l);
      endfunction

      function int cell_index(logic [LW-1:0] l);
         if (l == LETTER_J) l = LETTER_I;
         return int'(where_is[l]);
      endfunction

      function void encode_pair(logic [LW-1:0] a, logic [LW-1:0] b, logic fin);
         int ca, cb, ra, ka, rb, kb, oa, ob;
         cipher_pair_type p;
         ca = cell_index(a);
         cb = cell_index(b);
         ra = ca / 5;
         ka = ca % 5;
         rb = cb / 5;
         kb = cb % 5;
         if (ra == rb) begin
            oa = ra * 5 + (ka + 1) % 5;
            ob = rb * 5 + (kb + 1) % 5;
         end else if (ka == kb) begin
            oa = ((ra + 1) % 5) * 5 + ka;
            ob = ((rb + 1) % 5) * 5 + kb;
         end else begin
            oa = ra * 5 + kb;
            ob = rb * 5 + ka;
         end
         p.first = grid[oa];
         p.second = grid[ob];
         p.last_pair = fin;
         due_pairs = {due_pairs, p};
      endfunction

      function void note_letter(logic kind, logic [LW-1:0] raw, logic fin);
         logic [LW-1:0] l;
         l = (raw > LAST_LETTER) ? LAST_LETTER : raw;
         if (kind == REQ_KEY) begin
            if (!key_active) reset_square();
            put_letter(int'(l));
            if (fin) begin
               fill_rest();
               key_active = 0;
            end else begin
               key_active = 1;
            end
            return;
         end
         if (key_active || filled < CELLS) begin
            fill_rest();
            key_active = 0;
         end
         if (!waiting) begin
            if (fin) begin
               encode_pair(l, LETTER_X, 1'b1);
            end else begin
               waiting = 1;
               held = l;
            end
            return;
         end
         if (held == l) begin
            if (held == LETTER_X) begin
               encode_pair(LETTER_X, LETTER_Q, 1'b0);
            end else begin
               encode_pair(held, LETTER_X, 1'b0);
            end
            if (fin) begin
               encode_pair(l, LETTER_X, 1'b1);
               waiting = 0;
               held = '0;
            end
            return;
         end
         encode_pair(held, l, fin);
         waiting = 0;
         held = '0;
      endfunction

      function void check_pair(logic [LW-1:0] f, logic [LW-1:0] s, logic lp);
         cipher_pair_type e;
         if (due_pairs.size() == 0) begin
            $error("unexpected pair first_cipher=%0d second_cipher=%0d last_pair=%0b", f, s, lp);
            errors++;
            return;
         end
         e = due_pairs.pop_front();
         if (f !== e.first) begin
            $error("first_cipher expected %0d actual %0d", e.first, f);
            errors++;
         end
         if (s !== e.second) begin
            $error("second_cipher expected %0d actual %0d", e.second, s);
            errors++;
         end
         if (lp !== e.last_pair) begin
            $error("last_pair expected %0b actual %0b", e.last_pair, lp);
            errors++;
         end
      endfunction

      function int outstanding();
         return due_pairs.size();
      endfunction
   endclass

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_type = REQ_KEY;
   logic [LW-1:0] req_letter = '0;
   logic          req_last = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [LW-1:0] rsp_first_cipher;
   logic [LW-1:0] rsp_second_cipher;
   logic          rsp_last_pair;

   cipher_scoreboard sb = new();
   int sent_count = 0;
   int hold_left = 0;
   bit hold_done = 0;
   int idle_cycles = 0;

   playfair_encryptor_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_letter        (req_letter),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_first_cipher  (rsp_first_cipher),
      .rsp_second_cipher (rsp_second_cipher),
      .rsp_last_pair     (rsp_last_pair)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_letter(logic kind, logic [LW-1:0] l, logic fin);
      bit tx_calm;
      tx_calm = (sent_count >= 700 && sent_count < 950);
      while (!tx_calm && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_letter <= l;
      req_last <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_letter(kind, l, fin);
      sent_count++;
   endtask

   task automatic send_key(int len, bit finish);
      int r;
      logic [LW-1:0] l;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 6) l = LW'($urandom_range(26, 31));
         else if (r < 14) l = LETTER_J;
         else l = LW'($urandom_range(0, 25));
         send_letter(REQ_KEY, l, finish && i == len - 1);
      end
   endtask

   task automatic send_message(int len, bit finish);
      int r;
      logic [LW-1:0] l, prev;
      prev = LW'($urandom_range(0, 25));
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 20) l = prev;
         else if (r < 30) l = LETTER_X;
         else if (r < 38) l = LETTER_J;
         else if (r < 43) l = LW'($urandom_range(26, 31));
         else l = LW'($urandom_range(0, 25));
         send_letter(REQ_MSG, l, finish && i == len - 1);
         prev = l;
      end
   endtask

   // result side: random stall, one long hold-off to back the block up
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_pair(rsp_first_cipher, rsp_second_cipher, rsp_last_pair);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && sent_count >= 400) begin
         hold_done = 1;
         hold_left = HOLD_LEN;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !(sent_count >= 1000 && sent_count < 1250) &&
                      ($urandom_range(0, 99) < 36);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("playfair_encryptor_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int r, klen;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // message straight after reset: default square, out-of-range, doubled x, padded xx
      send_letter(REQ_MSG, 5'd0, 1'b0);
      send_letter(REQ_MSG, 5'd31, 1'b0);
      send_letter(REQ_MSG, LETTER_X, 1'b0);
      send_letter(REQ_MSG, LETTER_X, 1'b0);
      send_letter(REQ_MSG, LETTER_X, 1'b1);
      // key with repeats, j and a saturated letter
      send_letter(REQ_KEY, 5'd15, 1'b0);
      send_letter(REQ_KEY, 5'd11, 1'b0);
      send_letter(REQ_KEY, 5'd0, 1'b0);
      send_letter(REQ_KEY, 5'd24, 1'b0);
      send_letter(REQ_KEY, LETTER_J, 1'b0);
      send_letter(REQ_KEY, 5'd15, 1'b0);
      send_letter(REQ_KEY, 5'd30, 1'b1);
      // j as i, a letter repeated across two pairs, then a lone final letter
      send_letter(REQ_MSG, LETTER_J, 1'b0);
      send_letter(REQ_MSG, 5'd4, 1'b0);
      send_letter(REQ_MSG, 5'd4, 1'b0);
      send_letter(REQ_MSG, 5'd18, 1'b1);
      send_letter(REQ_MSG, 5'd7, 1'b1);
      // key left open when the message starts
      send_letter(REQ_KEY, 5'd2, 1'b0);
      send_letter(REQ_KEY, 5'd1, 1'b0);
      send_letter(REQ_MSG, LETTER_Q, 1'b0);
      send_letter(REQ_MSG, 5'd31, 1'b1);

      while (sent_count < ITEMS) begin
         r = $urandom_range(0, 99);
         klen = ($urandom_range(0, 99) < 8) ? $urandom_range(20, 30) : $urandom_range(1, 10);
         if (r < 80) begin
            send_key(klen, 1);
            send_message($urandom_range(1, 20), 1);
         end else if (r < 88) begin
            send_key(klen, 0);
            send_message($urandom_range(1, 20), 1);
         end else if (r < 94) begin
            send_message($urandom_range(1, 20), 1);
         end else begin
            send_message($urandom_range(1, 12), 0);
         end
      end
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0) begin
         $display("playfair_encryptor_top: match");
      end else begin
         $display("playfair_encryptor_top: mismatch");
      end
      $finish;
   end

endmodule
